/* rtl/cdq_pkg.sv */
package cdq_pkg;

    localparam int MAX_DEPTH_DEF  = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CAP_W          = 11;
    localparam int OP_W           = 3;
    localparam int VALUE_W        = 32;
    localparam int CAP_RESET      = 1024;

    localparam logic signed [VALUE_W-1:0] EMPTY_WORD = -32'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

/* rtl/cdq_ram.sv */
module cdq_ram
    import cdq_pkg::*;
#(
    parameter int WIDTH = DATA_WIDTH_DEF,
    parameter int DEPTH = MAX_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/circular_deque.sv */
// Channel  | Direction | Handshake               | Word
// ---------+-----------+-------------------------+-----------------------------------
// in       | input     | i_in_valid / o_in_stall | i_op, i_value
// out      | output    | o_out_valid/ i_out_stall| o_accepted, o_front_value,
//          |           |                         | o_rear_value, o_is_empty, o_is_full
// cfg      | input     | i_cfg_valid/ o_cfg_ready| i_cfg_capacity
//
// One word at a time: the accept cycle updates the indices and issues the reads of
// both ends, and the read state loads the result from the two RAM copies.
// Reset (synchronous, active low) empties the queue; the RAM is not cleared.
// A stalled result holds in the output register; one more word may be taken and
// waits in the read state until it moves, then input stalls.
// A capacity write empties the queue and blocks input words in that cycle.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OP_W-1:0]           i_op,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_accepted,
    output logic signed [VALUE_W-1:0] o_front_value,
    output logic signed [VALUE_W-1:0] o_rear_value,
    output logic                      o_is_empty,
    output logic                      o_is_full,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CAP_W-1:0]          i_cfg_capacity
);

    localparam int IDX_W    = $clog2(MAX_DEPTH);
    localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
    localparam int CAP_INIT = (CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : CAP_RESET;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count, r_cap, n_cap, cfg_cap;
    logic r_acc, n_acc;
    logic we;
    logic [IDX_W-1:0] waddr;
    logic signed [DATA_WIDTH-1:0] wdata, r_wdata;
    logic r_fwd_front, r_fwd_rear;
    logic signed [DATA_WIDTH-1:0] ram_front, ram_rear, front_word, rear_word;
    logic accept, cfg_wr, load, has_room, has_entry;
    logic r_out_valid, r_out_acc, r_out_empty, r_out_full;
    logic signed [VALUE_W-1:0] r_out_front, r_out_rear;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign has_room    = (r_count < r_cap);
    assign has_entry   = (r_count != '0);
    assign wdata       = DATA_WIDTH'(i_value);

    always_comb begin
        if (i_cfg_capacity == '0) begin
            cfg_cap = CNT_W'(1);
        end else if (32'(i_cfg_capacity) > 32'(MAX_DEPTH)) begin
            cfg_cap = CNT_W'(MAX_DEPTH);
        end else begin
            cfg_cap = CNT_W'(i_cfg_capacity);
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_cap   = r_cap;
        n_acc   = r_acc;
        we      = 1'b0;
        waddr   = r_head;
        if (cfg_wr) begin
            n_cap   = cfg_cap;
            n_head  = '0;
            n_tail  = IDX_W'(cfg_cap - 1'b1);
            n_count = '0;
        end else if (accept) begin
            n_acc = 1'b0;
            case (t_op'(i_op))
                OP_PUSH_FRONT: begin
                    if (has_room) begin
                        n_head  = (r_head == '0) ? IDX_W'(r_cap - 1'b1) : r_head - 1'b1;
                        we      = 1'b1;
                        waddr   = n_head;
                        n_count = r_count + 1'b1;
                        n_acc   = 1'b1;
                    end
                end
                OP_PUSH_REAR: begin
                    if (has_room) begin
                        n_tail  = (CNT_W'(r_tail) + 1'b1 >= r_cap) ? '0 : r_tail + 1'b1;
                        we      = 1'b1;
                        waddr   = n_tail;
                        n_count = r_count + 1'b1;
                        n_acc   = 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (has_entry) begin
                        n_head  = (CNT_W'(r_head) + 1'b1 >= r_cap) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                        n_acc   = 1'b1;
                    end
                end
                OP_POP_REAR: begin
                    if (has_entry) begin
                        n_tail  = (r_tail == '0) ? IDX_W'(r_cap - 1'b1) : r_tail - 1'b1;
                        n_count = r_count - 1'b1;
                        n_acc   = 1'b1;
                    end
                end
                OP_QUERY: begin
                    n_acc = 1'b1;
                end
                default: begin
                    n_acc = 1'b0;
                end
            endcase
        end
    end

    cdq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_DEPTH)) u_ram_front (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_head),
        .o_rdata (ram_front)
    );

    cdq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_DEPTH)) u_ram_rear (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_tail),
        .o_rdata (ram_rear)
    );

    // forward a word written in the same cycle as its read
    assign front_word = r_fwd_front ? r_wdata : ram_front;
    assign rear_word  = r_fwd_rear  ? r_wdata : ram_rear;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_READ:  load = !r_out_valid || !i_out_stall;
            default: load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= IDX_W'(CAP_INIT - 1);
            r_count     <= '0;
            r_cap       <= CNT_W'(CAP_INIT);
            r_out_valid <= 1'b0;
            r_fwd_front <= 1'b0;
            r_fwd_rear  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_fwd_front <= we && (waddr == n_head);
            r_fwd_rear  <= we && (waddr == n_tail);
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_wdata <= wdata;
        if (load) begin
            r_out_acc   <= r_acc;
            r_out_empty <= !has_entry;
            r_out_full  <= !has_room;
            r_out_front <= has_entry ? VALUE_W'(front_word) : EMPTY_WORD;
            r_out_rear  <= has_entry ? VALUE_W'(rear_word)  : EMPTY_WORD;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_out_acc;
    assign o_front_value = r_out_front;
    assign o_rear_value  = r_out_rear;
    assign o_is_empty    = r_out_empty;
    assign o_is_full     = r_out_full;

endmodule

/* rtl/cdq_checker.sv */
module cdq_checker
    import cdq_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_accepted,
    input logic signed [VALUE_W-1:0] o_front_value,
    input logic signed [VALUE_W-1:0] o_rear_value,
    input logic                      o_is_empty,
    input logic                      o_is_full
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_front_value)
            && $stable(o_rear_value) && $stable(o_accepted))
        else $error("stalled output word changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while one is in flight");

    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_front_value == EMPTY_WORD
            && o_rear_value == EMPTY_WORD)
        else $error("empty queue shows an end value");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_empty && o_is_full))
        else $error("queue both empty and full");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_accepted    (o_accepted),
    .o_front_value (o_front_value),
    .o_rear_value  (o_rear_value),
    .o_is_empty    (o_is_empty),
    .o_is_full     (o_is_full)
);

/* dv/testbench.sv */
module testbench;
    import cdq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 3'(OP_QUERY) + 3'd1;
    localparam logic [OP_W-1:0] OP_UNKNOWN_HI = '1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES = 12;
    localparam int PHASE_WORDS = 110;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic                      accepted;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] rear_value;
        logic                      is_empty;
        logic                      is_full;
    } t_deque_view;

    class deque_tracker;
        logic signed [VALUE_W-1:0] ring [MAX_DEPTH_DEF];
        int unsigned head;
        int unsigned tail;
        int unsigned count;
        int unsigned cap;
        int unsigned errors;
        t_deque_view expected_views[$];

        function new();
            foreach (ring[i]) ring[i] = '0;
            errors = 0;
            set_capacity(CAP_W'(CAP_RESET));
        endfunction

        function void set_capacity(logic [CAP_W-1:0] raw);
            if (raw == 0)
                cap = 1;
            else if (raw > MAX_DEPTH_DEF)
                cap = MAX_DEPTH_DEF;
            else
                cap = raw;
            head = 0;
            tail = cap - 1;
            count = 0;
        endfunction

        function int unsigned pending();
            return expected_views.size();
        endfunction

        function void note_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value);
            t_deque_view want;
            want.accepted = 1'b0;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_REAR: begin
                    if (count < cap) begin
                        if (op == OP_PUSH_FRONT) begin
                            head = (head == 0) ? cap - 1 : head - 1;
                            ring[head] = value;
                        end else begin
                            tail = (tail + 1 >= cap) ? 0 : tail + 1;
                            ring[tail] = value;
                        end
                        count++;
                        want.accepted = 1'b1;
                    end
                end
                OP_POP_FRONT, OP_POP_REAR: begin
                    if (count > 0) begin
                        if (op == OP_POP_FRONT)
                            head = (head + 1 >= cap) ? 0 : head + 1;
                        else
                            tail = (tail == 0) ? cap - 1 : tail - 1;
                        count--;
                        want.accepted = 1'b1;
                    end
                end
                OP_QUERY: want.accepted = 1'b1;
                default: ;
            endcase
            want.front_value = (count == 0) ? EMPTY_WORD : ring[head];
            want.rear_value  = (count == 0) ? EMPTY_WORD : ring[tail];
            want.is_empty    = (count == 0);
            want.is_full     = (count >= cap);
            expected_views.push_back(want);
        endfunction

        task report(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            errors++;
            $display("ERROR: %s got %h want %h", what, got, want);
        endtask

        task check_view(t_deque_view got);
            t_deque_view want;
            if (expected_views.size() == 0) begin
                report("unexpected word", got.front_value, '0);
                return;
            end
            want = expected_views.pop_front();
            if (got.accepted !== want.accepted)
                report("accepted", got.accepted, want.accepted);
            if (got.front_value !== want.front_value)
                report("front_value", got.front_value, want.front_value);
            if (got.rear_value !== want.rear_value)
                report("rear_value", got.rear_value, want.rear_value);
            if (got.is_empty !== want.is_empty)
                report("is_empty", got.is_empty, want.is_empty);
            if (got.is_full !== want.is_full)
                report("is_full", got.is_full, want.is_full);
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [OP_W-1:0]           i_op = OP_QUERY;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_accepted;
    logic signed [VALUE_W-1:0] o_front_value;
    logic signed [VALUE_W-1:0] o_rear_value;
    logic                      o_is_empty;
    logic                      o_is_full;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CAP_W-1:0]          i_cfg_capacity = '0;

    deque_tracker dq = new();
    bit quiet = 1'b0;
    int hold_cycles = 0;
    int idle_cycles = 0;

    circular_deque uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accepted     (o_accepted),
        .o_front_value  (o_front_value),
        .o_rear_value   (o_rear_value),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    function automatic int unsigned draw_gap();
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        dq.note_op(op, value);
    endtask

    // drop valid and hold until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (dq.pending() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] raw);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_capacity <= raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        dq.set_capacity(raw);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input bit filling);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return OP_W'($urandom_range(int'(OP_UNKNOWN_LO), int'(OP_UNKNOWN_HI)));
        if (r < 15)
            return OP_QUERY;
        if (r < 70)
            return filling ? ($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR)
                           : ($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR);
        return filling ? ($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR)
                       : ($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            default: return EMPTY_WORD;
        endcase
    endfunction

    initial begin : result_sink
        int unsigned n;
        t_deque_view got;
        wait (i_rst_n);
        forever begin
            n = draw_gap();
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got.accepted    = o_accepted;
            got.front_value = o_front_value;
            got.rear_value  = o_rear_value;
            got.is_empty    = o_is_empty;
            got.is_full     = o_is_full;
            dq.check_view(got);
        end
    end

    initial begin : stimulus
        logic [CAP_W-1:0] phase_caps [PHASES];
        bit filling;
        phase_caps = '{11'd1, 11'd2, 11'd3, 11'd0, 11'd7, 11'd16, 11'd2047, 11'd33,
                       11'd1024, 11'd5, 11'd12, 11'd1};
        phase_caps[11] = CAP_W'($urandom_range(1, 1024));
        filling = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_QUERY, '0);
        send_word(OP_POP_FRONT, 32'sd5);
        send_word(OP_POP_REAR, 32'sd6);
        send_word(OP_PUSH_FRONT, 32'sh7fff_ffff);
        send_word(OP_PUSH_REAR, 32'sh8000_0000);
        send_word(OP_PUSH_FRONT, EMPTY_WORD);
        send_word(OP_PUSH_REAR, '0);
        send_word(OP_QUERY, 32'sh5555_aaaa);
        send_word(OP_UNKNOWN_LO, 32'sd1);
        send_word(OP_UNKNOWN_LO + 3'd1, 32'sd2);
        send_word(OP_UNKNOWN_HI, 32'sd3);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_REAR, '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_REAR, '0);
        send_word(OP_POP_FRONT, '0);

        write_capacity(11'd0);
        send_word(OP_PUSH_REAR, 32'sh1234_5678);
        send_word(OP_PUSH_FRONT, 32'sd9);
        send_word(OP_PUSH_REAR, 32'sd10);
        send_word(OP_POP_REAR, '0);
        send_word(OP_POP_FRONT, '0);

        write_capacity(11'd2047);
        send_word(OP_PUSH_REAR, 32'sd1);

        write_capacity(11'd2);
        send_word(OP_PUSH_FRONT, 32'sh0bad_f00d);
        send_word(OP_PUSH_FRONT, 32'sh7654_3210);
        send_word(OP_PUSH_REAR, 32'sd11);
        send_word(OP_POP_REAR, '0);

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_caps[p]);
            quiet = (p == 2 || p == 8);
            if (p == 4)
                hold_cycles = LONG_HOLD;
            filling = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                send_word(pick_op(filling), pick_value());
                if (dq.count >= dq.cap)
                    filling = 1'b0;
                else if (dq.count == 0)
                    filling = 1'b1;
                else if ($urandom_range(0, 63) == 0)
                    filling = !filling;
                if (p == 6 && k == 40)
                    drain_results();
            end
        end

        quiet = 1'b0;
        drain_results();
        repeat (10) @(posedge i_clk);
        if (dq.pending() != 0)
            dq.report("words still expected", dq.pending(), '0);
        if (dq.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
